// ===== sv/flfd_pkg.sv =====
// Package with the shared types and constants of the flagged length frame deframer.
`default_nettype none

package flfd_pkg;

    // Field widths
    localparam int BYTE_W    = 8;
    localparam int FLAG_W    = 16;
    localparam int LEN_W     = 16;
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_START_FLAG = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_END_FLAG   = 2'd1;

    // Smallest legal value of the length field (it counts itself)
    localparam logic [LEN_W-1:0] MIN_LEN = 16'd2;

    // Deframer phase codes; codes 6 and 7 are unused and behave as hunting.
    typedef enum logic [2:0] {
        PH_HUNT   = 3'd0,
        PH_LEN_HI = 3'd1,
        PH_LEN_LO = 3'd2,
        PH_DATA   = 3'd3,
        PH_END_HI = 3'd4,
        PH_END_LO = 3'd5
    } phase_t;

    // Result kind codes
    typedef enum logic [1:0] {
        KIND_DATA    = 2'd0,
        KIND_GOOD    = 2'd1,
        KIND_BAD_END = 2'd2,
        KIND_BAD_LEN = 2'd3
    } kind_t;

    // One result item
    typedef struct packed {
        kind_t             kind;
        logic [BYTE_W-1:0] data;
        logic [LEN_W-1:0]  flen;
    } result_t;

endpackage

`default_nettype wire

// ===== sv/flfd_core.sv =====
// Per-byte frame parsing state machine: hunts the start flag, reads length, payload and end flag.
`default_nettype none

module flfd_core
    import flfd_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              accept,
    input  wire logic [BYTE_W-1:0] in_byte,
    input  wire logic [FLAG_W-1:0] start_flag,
    input  wire logic [FLAG_W-1:0] end_flag,
    output logic                   res_push,
    output result_t                res
);

    phase_t            phase_reg, phase_next;
    logic [BYTE_W-1:0] prev_reg, prev_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [LEN_W-1:0]  left_reg, left_next;
    logic [BYTE_W-1:0] endhi_reg, endhi_next;

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
            prev_reg  <= '0;
            len_reg   <= '0;
            left_reg  <= '0;
            endhi_reg <= '0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            prev_reg  <= prev_next;
            len_reg   <= len_next;
            left_reg  <= left_next;
            endhi_reg <= endhi_next;
        end
    end

    // Next state and the result caused by the current byte
    always_comb
    begin
        logic [LEN_W-1:0]  full_len;
        logic [FLAG_W-1:0] pair;

        full_len   = {len_reg[LEN_W-1:BYTE_W], in_byte};
        pair       = {prev_reg, in_byte};
        phase_next = phase_reg;
        prev_next  = prev_reg;
        len_next   = len_reg;
        left_next  = left_reg;
        endhi_next = endhi_reg;
        res_push   = 1'b0;
        res.kind   = KIND_DATA;
        res.data   = '0;
        res.flen   = '0;

        case (phase_reg)
            PH_LEN_HI:
            begin
                len_next   = {in_byte, {BYTE_W{1'b0}}};
                phase_next = PH_LEN_LO;
            end
            PH_LEN_LO:
            begin
                len_next = full_len;
                if (full_len < MIN_LEN)
                begin
                    // Length too short to count itself: report and resync.
                    res_push   = accept;
                    res.kind   = KIND_BAD_LEN;
                    res.flen   = full_len;
                    phase_next = PH_HUNT;
                    prev_next  = '0;
                end
                else
                begin
                    left_next  = full_len - MIN_LEN;
                    phase_next = (full_len == MIN_LEN) ? PH_END_HI : PH_DATA;
                end
            end
            PH_DATA:
            begin
                res_push  = accept;
                res.kind  = KIND_DATA;
                res.data  = in_byte;
                left_next = left_reg - 1'b1;
                if (left_reg == {{(LEN_W-1){1'b0}}, 1'b1})
                begin
                    phase_next = PH_END_HI;
                end
            end
            PH_END_HI:
            begin
                endhi_next = in_byte;
                phase_next = PH_END_LO;
            end
            PH_END_LO:
            begin
                res_push   = accept;
                res.kind   = ({endhi_reg, in_byte} == end_flag) ? KIND_GOOD : KIND_BAD_END;
                res.flen   = len_reg;
                phase_next = PH_HUNT;
                prev_next  = '0;
            end
            default:
            begin
                // Hunting: the previous byte keeps its value on a match.
                if (pair == start_flag)
                begin
                    phase_next = PH_LEN_HI;
                end
                else
                begin
                    phase_next = PH_HUNT;
                    prev_next  = in_byte;
                end
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== sv/flfd_outbuf.sv =====
// Two-entry result buffer: a registered head and a skid entry behind it.
`default_nettype none

module flfd_outbuf
    import flfd_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    push,
    input  wire result_t push_data,
    output logic         full,
    output logic         head_valid,
    output result_t      head,
    input  wire logic    head_stall
);

    logic    head_valid_reg, head_valid_next;
    result_t head_reg, head_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t skid_reg, skid_next;
    logic    pop;

    assign pop        = head_valid_reg && !head_stall;
    assign full       = skid_valid_reg;
    assign head_valid = head_valid_reg;
    assign head       = head_reg;

    // Buffer control; a push only comes while the skid entry is free.
    always_comb
    begin
        head_valid_next = head_valid_reg;
        head_next       = head_reg;
        skid_valid_next = skid_valid_reg;
        skid_next       = skid_reg;
        if (pop)
        begin
            if (skid_valid_reg)
            begin
                head_next       = skid_reg;
                skid_valid_next = push;
                skid_next       = push_data;
            end
            else
            begin
                head_valid_next = push;
                head_next       = push_data;
            end
        end
        else if (!head_valid_reg)
        begin
            head_valid_next = push;
            head_next       = push_data;
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
            skid_next       = push_data;
        end
    end

    // Control flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            head_valid_reg <= head_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Payload entries
    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        skid_reg <= skid_next;
    end

endmodule

`default_nettype wire

// ===== sv/flagged_length_frame_deframer.sv =====
// Top level of the flagged length frame deframer.
//
//   channel  direction  handshake            payload
//   input    in         in_valid / in_stall  in_byte
//   result   out        res_valid/res_stall  kind, out_byte, frame_len
//   config   in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One byte is taken every clock while in_stall is low; its result, if any, is registered
// in the two-entry result buffer and shows at res_valid once earlier results are taken.
// in_stall rises only when both buffer entries hold results that are not yet taken.
// Reset returns the parser to hunting and clears both flag registers and the buffer.
// cfg_ready is always high; writes to an unknown index are dropped.
`default_nettype none

module flagged_length_frame_deframer
    import flfd_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic [BYTE_W-1:0]    in_byte,
    output logic                      res_valid,
    input  wire logic                 res_stall,
    output logic [1:0]                kind,
    output logic [BYTE_W-1:0]         out_byte,
    output logic [LEN_W-1:0]          frame_len,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [FLAG_W-1:0]    cfg_data
);

    logic [FLAG_W-1:0] start_flag_reg;
    logic [FLAG_W-1:0] end_flag_reg;
    logic              accept;
    logic              buf_full;
    logic              res_push;
    result_t           res;
    result_t           head;

    assign cfg_ready = 1'b1;
    assign in_stall  = buf_full;
    assign accept    = in_valid && !buf_full;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_flag_reg <= '0;
            end_flag_reg   <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_START_FLAG: start_flag_reg <= cfg_data;
                CFG_END_FLAG:   end_flag_reg   <= cfg_data;
                default:        ;
            endcase
        end
    end

    // Frame parser
    flfd_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .in_byte    (in_byte),
        .start_flag (start_flag_reg),
        .end_flag   (end_flag_reg),
        .res_push   (res_push),
        .res        (res)
    );

    // Result buffer
    flfd_outbuf u_outbuf (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (res_push),
        .push_data  (res),
        .full       (buf_full),
        .head_valid (res_valid),
        .head       (head),
        .head_stall (res_stall)
    );

    assign kind      = head.kind;
    assign out_byte  = head.data;
    assign frame_len = head.flen;

endmodule

`default_nettype wire

// ===== tb/sv/flfd_checker.sv =====
// Checker for the flagged length frame deframer: predicts results and compares them.
`timescale 1ns / 100ps

module flfd_checker
    import flfd_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    input  wire logic                 in_stall,
    input  wire logic [BYTE_W-1:0]    in_byte,
    input  wire logic                 res_valid,
    input  wire logic                 res_stall,
    input  wire logic [1:0]           kind,
    input  wire logic [BYTE_W-1:0]    out_byte,
    input  wire logic [LEN_W-1:0]     frame_len,
    input  wire logic                 cfg_valid,
    input  wire logic                 cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [FLAG_W-1:0]    cfg_data,
    output int                        fails,
    output int                        pending
);

    // Local copy of the flag registers and the parser state.
    logic [FLAG_W-1:0] start_flag_q;
    logic [FLAG_W-1:0] end_flag_q;
    phase_t            phase_q;
    logic [BYTE_W-1:0] prev_q;
    logic [LEN_W-1:0]  len_q;
    logic [LEN_W-1:0]  left_q;
    logic [BYTE_W-1:0] end_hi_q;

    // Results that the bytes taken so far must still produce, oldest first.
    result_t deframed_q[$];
    result_t want;
    result_t got;

    // Queue one result item.
    function automatic void push_result(kind_t k, logic [BYTE_W-1:0] d, logic [LEN_W-1:0] l);
        result_t r;
        r.kind = k;
        r.data = d;
        r.flen = l;
        deframed_q.push_back(r);
    endfunction

    // Advance the parser by one received byte.
    function automatic void deframe_byte(logic [BYTE_W-1:0] b);
        logic [LEN_W-1:0]  full_len;
        logic [FLAG_W-1:0] pair;
        full_len = {len_q[LEN_W-1:BYTE_W], b};
        pair     = {end_hi_q, b};
        case (phase_q)
            PH_LEN_HI:
            begin
                len_q   = {b, 8'h00};
                phase_q = PH_LEN_LO;
            end
            PH_LEN_LO:
            begin
                len_q = full_len;
                if (full_len < MIN_LEN)
                begin
                    // Length too short to cover itself: report and resume hunting.
                    push_result(KIND_BAD_LEN, '0, full_len);
                    phase_q = PH_HUNT;
                    prev_q  = '0;
                end
                else
                begin
                    left_q  = full_len - MIN_LEN;
                    phase_q = (left_q == 0) ? PH_END_HI : PH_DATA;
                end
            end
            PH_DATA:
            begin
                push_result(KIND_DATA, b, '0);
                left_q = left_q - 1'b1;
                if (left_q == 0)
                    phase_q = PH_END_HI;
            end
            PH_END_HI:
            begin
                end_hi_q = b;
                phase_q  = PH_END_LO;
            end
            PH_END_LO:
            begin
                push_result((pair == end_flag_q) ? KIND_GOOD : KIND_BAD_END, '0, len_q);
                phase_q = PH_HUNT;
                prev_q  = '0;
            end
            default:
            begin
                // Hunting: the previous byte stays put when the start flag matches.
                if ({prev_q, b} == start_flag_q)
                    phase_q = PH_LEN_HI;
                else
                begin
                    phase_q = PH_HUNT;
                    prev_q  = b;
                end
            end
        endcase
    endfunction

    // Follow the three channels at each clock edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_flag_q = '0;
            end_flag_q   = '0;
            phase_q      = PH_HUNT;
            prev_q       = '0;
            len_q        = '0;
            left_q       = '0;
            end_hi_q     = '0;
            deframed_q.delete();
            fails        = 0;
            pending      = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_START_FLAG)
                    start_flag_q = cfg_data;
                else if (cfg_index == CFG_END_FLAG)
                    end_flag_q = cfg_data;
            end

            if (in_valid && !in_stall)
                deframe_byte(in_byte);

            if (res_valid && !res_stall)
            begin
                got.kind = kind_t'(kind);
                got.data = out_byte;
                got.flen = frame_len;
                if (deframed_q.size() == 0)
                begin
                    fails++;
                    if (fails <= 10)
                        $display("%0t: unexpected result: kind %0d byte %02h len %04h",
                                 $realtime, kind, out_byte, frame_len);
                end
                else
                begin
                    want = deframed_q.pop_front();
                    if (got.kind != want.kind || got.data != want.data
                        || got.flen != want.flen)
                    begin
                        fails++;
                        if (fails <= 10)
                            $display({"%0t: wrong result (expected/actual): ",
                                      "kind %0d/%0d byte %02h/%02h len %04h/%04h"},
                                     $realtime, want.kind, got.kind, want.data, got.data,
                                     want.flen, got.flen);
                    end
                end
            end
            pending = deframed_q.size();
        end
    end

endmodule

// ===== tb/sv/tb_top.sv =====
// Top of the deframer testbench: clock, reset, byte stimulus, sink stalls and verdict.
`timescale 1ns / 100ps

module tb_top;
    import flfd_pkg::*;

    localparam int ITEMS      = 1500;
    localparam int IDLE_LIMIT = 5000;
    localparam int HOLD_LEN   = 300;
    localparam int SETTLE     = 4;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 2'd2;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic [BYTE_W-1:0]    in_byte   = '0;
    logic                 res_stall = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [FLAG_W-1:0]    cfg_data  = '0;
    logic                 in_stall;
    logic                 res_valid;
    logic [1:0]           kind;
    logic [BYTE_W-1:0]    out_byte;
    logic [LEN_W-1:0]     frame_len;
    logic                 cfg_ready;

    // Stimulus controls seen by the sink and the source.
    logic steady  = 1'b0;
    logic hold_go = 1'b0;
    int   fails;
    int   pending;
    int   bytes_sent = 0;
    logic [FLAG_W-1:0] cur_start = '0;
    logic [FLAG_W-1:0] cur_end   = '0;

    flagged_length_frame_deframer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_byte   (in_byte),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .kind      (kind),
        .out_byte  (out_byte),
        .frame_len (frame_len),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    flfd_checker u_check (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_byte   (in_byte),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .kind      (kind),
        .out_byte  (out_byte),
        .frame_len (frame_len),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .fails     (fails),
        .pending   (pending)
    );

    // Clock with a 2 ns period.
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Result sink: random stalls, plus one long hold-off when asked for.
    int  hold_left = 0;
    bit  hold_seen = 1'b0;
    always @(posedge clk)
    begin
        if (hold_go && !hold_seen)
        begin
            hold_seen = 1'b1;
            hold_left = HOLD_LEN;
        end
        if (!rst_n)
            res_stall <= 1'b0;
        else if (hold_left > 0)
        begin
            hold_left--;
            res_stall <= 1'b1;
        end
        else
            res_stall <= !steady && ($urandom_range(99) < 26);
    end

    // Watchdog: too many cycles in a row with no handshake at all.
    int idle_cycles = 0;
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (res_valid && !res_stall) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("flagged_length_frame_deframer: mismatch");
                $finish;
            end
        end
    end

    // Offer one byte, with random idle cycles ahead of it, and wait until it is taken.
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        while (!steady && $urandom_range(99) < 26)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_byte  <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        bytes_sent++;
    endtask

    // Stop sending and wait until every predicted result has been taken.
    task automatic drain();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Write one flag register.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [FLAG_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == CFG_START_FLAG)
            cur_start = val;
        else if (idx == CFG_END_FLAG)
            cur_end = val;
    endtask

    // Send a frame under the current flags; cut_at below zero sends it whole.
    task automatic send_frame(input logic [LEN_W-1:0] flen, input bit end_ok, input int cut_at);
        logic [BYTE_W-1:0] seq[$];
        logic [FLAG_W-1:0] tail;
        seq = {cur_start[15:8], cur_start[7:0], flen[15:8], flen[7:0]};
        if (flen >= MIN_LEN)
        begin
            for (int i = 0; i < int'(flen) - 2; i++)
                seq.push_back(BYTE_W'($urandom_range(255)));
            tail = cur_end;
            if (!end_ok)
                tail = cur_end ^ FLAG_W'($urandom_range(16'hFFFF, 1));
            seq.push_back(tail[15:8]);
            seq.push_back(tail[7:0]);
        end
        if (cut_at >= 0 && cut_at < seq.size())
            seq = seq[0:cut_at];
        foreach (seq[i])
            send_byte(seq[i]);
    endtask

    // Flag value for a new setting, leaning on the extremes.
    function automatic logic [FLAG_W-1:0] pick_flag();
        int r;
        r = $urandom_range(9);
        if (r == 0)
            return '0;
        else if (r == 1)
            return '1;
        return FLAG_W'($urandom);
    endfunction

    // Main stimulus.
    initial
    begin
        int frames_left;
        int r;
        logic [LEN_W-1:0] flen;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset flags are zero, so a single zero byte after reset already matches.
        send_byte(8'h00);
        send_byte(8'h00);
        send_byte(8'h01);
        send_byte(8'h00);
        send_byte(8'h00);
        send_byte(8'h00);
        send_byte(8'h00);
        send_byte(8'h00);
        send_byte(8'h02);
        send_byte(8'h00);
        send_byte(8'h00);
        drain();

        // Out-of-range index is dropped; then the flag extremes and a plain pattern.
        write_reg(CFG_IDX_UNUSED, 16'h1234);
        write_reg(CFG_START_FLAG, 16'hA5C3);
        write_reg(CFG_END_FLAG, 16'hFFFF);
        send_frame(16'd3, 1'b1, -1);
        send_frame(16'd4, 1'b0, -1);
        drain();
        write_reg(CFG_START_FLAG, 16'hFFFF);
        write_reg(CFG_END_FLAG, 16'h0000);
        send_frame(16'd2, 1'b1, -1);

        // Random frames under changing flags, mostly well formed.
        frames_left = 0;
        while (bytes_sent < ITEMS)
        begin
            if (frames_left == 0)
            begin
                drain();
                write_reg(CFG_START_FLAG, pick_flag());
                write_reg(CFG_END_FLAG, pick_flag());
                frames_left = $urandom_range(40, 10);
            end
            frames_left--;

            if (bytes_sent >= 600 && !hold_go)
                hold_go <= 1'b1;
            steady <= (bytes_sent >= 900 && bytes_sent < 1100);

            // Noise between frames now and then.
            if ($urandom_range(99) < 20)
                repeat ($urandom_range(4, 1)) send_byte(BYTE_W'($urandom_range(255)));

            r = $urandom_range(99);
            if (r < 82)
                flen = LEN_W'($urandom_range(10, 2));
            else if (r < 88)
                flen = LEN_W'($urandom_range(1, 0));
            else if (r < 95)
                flen = LEN_W'($urandom_range(300, 11));
            else
                flen = LEN_W'($urandom);

            // Huge random lengths are only ever sent as broken frames.
            if (flen > 16'd300)
                send_frame(flen, 1'b1, $urandom_range(8, 2));
            else if ($urandom_range(99) < 8)
                send_frame(flen, 1'b1, $urandom_range(int'(flen) + 2, 1));
            else
                send_frame(flen, $urandom_range(99) < 75, -1);
        end

        // Wrap up: stop sending and wait for the remaining results.
        steady <= 1'b0;
        drain();
        repeat (8) @(posedge clk);
        if (fails == 0)
            $display("flagged_length_frame_deframer: match");
        else
            $display("flagged_length_frame_deframer: mismatch");
        $finish;
    end

endmodule
